FILE: rtl/lmhf_pkg.sv
package lmhf_pkg;

  localparam int MAX_COLUMNS = 1024;
  localparam int MAX_ROWS    = 1024;
  localparam int PIXEL_BITS  = 16;

  localparam int COL_W   = $clog2(MAX_COLUMNS);
  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CSIZE_W = $clog2(MAX_COLUMNS + 1);
  localparam int RSIZE_W = $clog2(MAX_ROWS + 1);

  localparam int THR_W    = 16;
  localparam int POS_W    = 10;
  localparam int INC_W    = 17;
  localparam int FSIZE_W  = 11;
  localparam int CFG_W    = 16;
  localparam int CMP_W    = (PIXEL_BITS > THR_W) ? PIXEL_BITS : THR_W;
  localparam int DIFF_W   = CMP_W + 2;
  localparam int INC_MAX  = 65535;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIXEL_BITS-1:0] pix_t;
  typedef logic [THR_W-1:0]      thr_t;
  typedef logic [COL_W-1:0]      col_t;
  typedef logic [ROW_W-1:0]      row_t;
  typedef logic [POS_W-1:0]      pos_t;
  typedef logic signed [INC_W-1:0] inc_t;

  typedef enum logic [2:0] {
    REG_GLOBAL_THRESHOLD   = 3'd0,
    REG_THRESHOLD_SOURCE   = 3'd1,
    REG_NEIGHBOURHOOD_MODE = 3'd2,
    REG_ACCUMULATE_MODE    = 3'd3,
    REG_PEDESTAL_OFFSET    = 3'd4,
    REG_FRAME_ROWS         = 3'd5,
    REG_FRAME_COLUMNS      = 3'd6
  } reg_idx_e;

  typedef struct packed {
    thr_t global_threshold;
    logic threshold_source;
    logic neighbourhood_mode;
    logic accumulate_mode;
    thr_t pedestal_offset;
  } cfg_t;

  typedef struct packed {
    row_t row;
    col_t column;
    logic last;
    pix_t pixel;
    thr_t pixel_threshold;
  } s1_t;

  typedef struct packed {
    pos_t row;
    pos_t column;
    logic hit;
    inc_t increment;
    logic frame_last;
  } res_t;

  function automatic logic pix_gt(input pix_t a, input thr_t b);
    return CMP_W'(a) > CMP_W'(b);
  endfunction

  function automatic inc_t make_increment(input pix_t pix, input logic sum_mode,
                                          input thr_t offset);
    logic signed [DIFF_W-1:0] d;
    d = $signed(DIFF_W'(pix)) - $signed(DIFF_W'(offset));
    if (!sum_mode) return INC_W'(1);
    if (d > $signed(DIFF_W'(INC_MAX))) return INC_W'(INC_MAX);
    if (d < -$signed(DIFF_W'(INC_MAX))) return -INC_W'(INC_MAX);
    return INC_W'(d);
  endfunction

endpackage

FILE: rtl/lmhf_line_ram.sv
module lmhf_line_ram import lmhf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic acc_i,
  input  col_t addr_i,
  input  pix_t pixel_i,
  input  thr_t thr_i,
  output pix_t up_o,
  output pix_t mid_o,
  output thr_t tl_o
);

  pix_t upper_mem  [MAX_COLUMNS];
  pix_t middle_mem [MAX_COLUMNS];
  thr_t thresh_mem [MAX_COLUMNS];

  pix_t up_rd_q, mid_rd_q;
  thr_t tl_rd_q;
  logic wb_q;
  col_t wb_addr_q;

  // upper line is written back in the cycle after the read, with the middle read data
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      mid_rd_q           <= middle_mem[addr_i];
      tl_rd_q            <= thresh_mem[addr_i];
      middle_mem[addr_i] <= pixel_i;
      thresh_mem[addr_i] <= thr_i;
      if (wb_q && (wb_addr_q == addr_i)) begin
        up_rd_q <= mid_rd_q;
      end else begin
        up_rd_q <= upper_mem[addr_i];
      end
      wb_addr_q <= addr_i;
    end
    if (wb_q) begin
      upper_mem[wb_addr_q] <= mid_rd_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wb_q <= 1'b0;
    end else begin
      wb_q <= acc_i;
    end
  end

  assign up_o  = up_rd_q;
  assign mid_o = mid_rd_q;
  assign tl_o  = tl_rd_q;

endmodule

FILE: rtl/lmhf_window.sv
module lmhf_window import lmhf_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s1_valid_i,
  input  s1_t  s1_i,
  input  pix_t up_i,
  input  pix_t mid_i,
  input  thr_t tl_i,
  input  cfg_t cfg_i,
  output logic busy_o,
  output logic push_o,
  output res_t res_o
);

  pix_t win_q [9];
  thr_t ctr_q [2];

  logic s2_valid_q, s2_res_q;
  pos_t s2_row_q, s2_col_q;
  logic s2_last_q;
  pix_t s2_pix_q;
  thr_t s2_pthr_q;

  logic s2_res_d;
  pix_t test_pix;
  thr_t thr;
  logic hit;

  always_comb begin
    if (cfg_i.neighbourhood_mode) begin
      s2_res_d = (s1_i.row >= ROW_W'(2)) && (s1_i.column >= COL_W'(2));
    end else begin
      s2_res_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_i) begin
      for (int i = 0; i < 3; i++) begin
        win_q[i*3]   <= win_q[i*3+1];
        win_q[i*3+1] <= win_q[i*3+2];
      end
      win_q[2]  <= up_i;
      win_q[5]  <= mid_i;
      win_q[8]  <= s1_i.pixel;
      ctr_q[1]  <= ctr_q[0];
      ctr_q[0]  <= tl_i;
      s2_last_q <= s1_i.last;
      s2_pix_q  <= s1_i.pixel;
      s2_pthr_q <= s1_i.pixel_threshold;
      if (cfg_i.neighbourhood_mode) begin
        s2_row_q <= POS_W'(s1_i.row - ROW_W'(1));
        s2_col_q <= POS_W'(s1_i.column - COL_W'(1));
      end else begin
        s2_row_q <= POS_W'(s1_i.row);
        s2_col_q <= POS_W'(s1_i.column);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_res_q   <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_i;
      s2_res_q   <= s1_valid_i && s2_res_d;
    end
  end

  always_comb begin
    if (cfg_i.neighbourhood_mode) begin
      test_pix = win_q[4];
      thr      = cfg_i.threshold_source ? ctr_q[1] : cfg_i.global_threshold;
    end else begin
      test_pix = s2_pix_q;
      thr      = cfg_i.threshold_source ? s2_pthr_q : cfg_i.global_threshold;
    end
    hit = pix_gt(test_pix, thr);
    if (cfg_i.neighbourhood_mode) begin
      for (int i = 0; i < 9; i++) begin
        if (i != 4 && !(win_q[4] > win_q[i])) hit = 1'b0;
      end
    end
  end

  assign busy_o            = s2_valid_q;
  assign push_o            = s2_valid_q && s2_res_q;
  assign res_o.row         = s2_row_q;
  assign res_o.column      = s2_col_q;
  assign res_o.hit         = hit;
  assign res_o.increment   = hit ? make_increment(test_pix, cfg_i.accumulate_mode,
                                                  cfg_i.pedestal_offset) : '0;
  assign res_o.frame_last  = s2_last_q;

endmodule

FILE: rtl/lmhf_out_fifo.sv
module lmhf_out_fifo import lmhf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  res_t                 res_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output res_t                 res_o,
  output logic [FIFO_CW-1:0]   count_o
);

  res_t buf_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_CW-1:0] cnt_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_q] <= res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (32'(wr_q) == FIFO_DEPTH - 1) ? '0 : wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= (32'(rd_q) == FIFO_DEPTH - 1) ? '0 : rd_q + FIFO_AW'(1);
      end
      cnt_q <= cnt_q + FIFO_CW'(push_i) - FIFO_CW'(pop_i);
    end
  end

  assign valid_o = cnt_q != '0;
  assign res_o   = buf_q[rd_q];
  assign count_o = cnt_q;

endmodule

FILE: rtl/local_max_hit_finder_core.sv
// Local-maximum hit finder. Pixels enter in raster order, one beat per clock
// when the output side keeps up; each result passes through the s1 and s2
// stage registers and the output queue. Three 1024-entry line memories (upper
// and middle pixel lines, per-pixel thresholds) are read and written once
// per beat; the upper line is written back in the cycle after the read, with
// forwarding, so one-column frames also run at full rate. In local-maximum
// mode the result for a pixel comes one row and one column late and only for
// interior positions; in excess mode every pixel yields a result for itself.
// A four-entry output queue absorbs back-pressure; input ready drops when the
// queue plus the two in-flight stages would overflow it. Configuration writes
// are always taken and must only be made while the block is idle.
module local_max_hit_finder_core import lmhf_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pix_t                pixel_i,
  input  thr_t                pixel_threshold_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [POS_W-1:0]    row_o,
  output logic [POS_W-1:0]    column_o,
  output logic                hit_o,
  output logic signed [INC_W-1:0] increment_o,
  output logic                frame_last_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [CFG_W-1:0]    cfg_data_i
);

  cfg_t cfg_q;
  logic [FSIZE_W-1:0] rows_q, cols_q;
  row_t r_q, r_d;
  col_t c_q, c_d;
  logic s1_valid_q;
  s1_t  s1_q;

  logic [RSIZE_W-1:0] rows_eff;
  logic [CSIZE_W-1:0] cols_eff;
  logic acc, col_end, row_end;

  pix_t up_rd, mid_rd;
  thr_t tl_rd;
  logic s2_busy, push, pop, fifo_valid;
  res_t push_res, head_res;
  logic [FIFO_CW-1:0] fifo_cnt;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.global_threshold   <= '0;
      cfg_q.threshold_source   <= 1'b0;
      cfg_q.neighbourhood_mode <= 1'b1;
      cfg_q.accumulate_mode    <= 1'b0;
      cfg_q.pedestal_offset    <= '0;
      rows_q                   <= FSIZE_W'(1024);
      cols_q                   <= FSIZE_W'(1024);
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_GLOBAL_THRESHOLD:   cfg_q.global_threshold   <= cfg_data_i;
        REG_THRESHOLD_SOURCE:   cfg_q.threshold_source   <= cfg_data_i[0];
        REG_NEIGHBOURHOOD_MODE: cfg_q.neighbourhood_mode <= cfg_data_i[0];
        REG_ACCUMULATE_MODE:    cfg_q.accumulate_mode    <= cfg_data_i[0];
        REG_PEDESTAL_OFFSET:    cfg_q.pedestal_offset    <= cfg_data_i;
        REG_FRAME_ROWS:         rows_q <= cfg_data_i[FSIZE_W-1:0];
        REG_FRAME_COLUMNS:      cols_q <= cfg_data_i[FSIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (rows_q == '0) begin
      rows_eff = RSIZE_W'(1);
    end else if (32'(rows_q) > MAX_ROWS) begin
      rows_eff = RSIZE_W'(MAX_ROWS);
    end else begin
      rows_eff = RSIZE_W'(rows_q);
    end
    if (cols_q == '0) begin
      cols_eff = CSIZE_W'(1);
    end else if (32'(cols_q) > MAX_COLUMNS) begin
      cols_eff = CSIZE_W'(MAX_COLUMNS);
    end else begin
      cols_eff = CSIZE_W'(cols_q);
    end
  end

  assign in_ready_o = (FIFO_CW'(fifo_cnt) + FIFO_CW'(s1_valid_q) + FIFO_CW'(s2_busy))
                      < FIFO_CW'(FIFO_DEPTH);
  assign acc     = in_valid_i && in_ready_o;
  assign col_end = (CSIZE_W'(c_q) + CSIZE_W'(1)) >= cols_eff;
  assign row_end = (RSIZE_W'(r_q) + RSIZE_W'(1)) >= rows_eff;

  always_comb begin
    r_d = r_q;
    c_d = c_q + COL_W'(1);
    if (col_end) begin
      c_d = '0;
      r_d = row_end ? '0 : r_q + ROW_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q        <= '0;
      c_q        <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= acc;
      if (acc) begin
        r_q <= r_d;
        c_q <= c_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q.row             <= r_q;
      s1_q.column          <= c_q;
      s1_q.last            <= col_end && row_end;
      s1_q.pixel           <= pixel_i;
      s1_q.pixel_threshold <= pixel_threshold_i;
    end
  end

  lmhf_line_ram u_line_ram (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .acc_i   (acc),
    .addr_i  (c_q),
    .pixel_i (pixel_i),
    .thr_i   (pixel_threshold_i),
    .up_o    (up_rd),
    .mid_o   (mid_rd),
    .tl_o    (tl_rd)
  );

  lmhf_window u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid_q),
    .s1_i       (s1_q),
    .up_i       (up_rd),
    .mid_i      (mid_rd),
    .tl_i       (tl_rd),
    .cfg_i      (cfg_q),
    .busy_o     (s2_busy),
    .push_o     (push),
    .res_o      (push_res)
  );

  assign pop = fifo_valid && out_ready_i;

  lmhf_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (push_res),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .res_o   (head_res),
    .count_o (fifo_cnt)
  );

  assign out_valid_o  = fifo_valid;
  assign row_o        = head_res.row;
  assign column_o     = head_res.column;
  assign hit_o        = head_res.hit;
  assign increment_o  = head_res.increment;
  assign frame_last_o = head_res.frame_last;

endmodule

FILE: rtl/lmhf_checker.sv
module lmhf_checker import lmhf_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input logic [POS_W-1:0]    row_o,
  input logic [POS_W-1:0]    column_o,
  input logic                hit_o,
  input logic signed [INC_W-1:0] increment_o,
  input logic                frame_last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(row_o) && $stable(column_o)
      && $stable(hit_o) && $stable(increment_o) && $stable(frame_last_o))
    else $error("result beat changed while stalled");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> increment_o == '0)
    else $error("nonzero increment without hit");

  a_inc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> increment_o != {1'b1, {(INC_W-1){1'b0}}})
    else $error("increment outside saturation range");

  a_out_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 3))
    else $error("result without an input beat three clocks earlier");

endmodule

bind local_max_hit_finder_core lmhf_checker u_checker (.*);
